/* rtl/core/assert_macros.svh */
// Assertion macros shared by the interpolator RTL.
// Included by the modules that carry concurrent assertions; no other dependencies.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef SYNTHESIS
// Asserts a property on the rising edge of clk, ignored while rst is high.
`define ASSERT_PROP(lbl, clk, rst, prop) \
  lbl: assert property (@(posedge clk) disable iff (rst) prop) \
    else $error("concurrent assertion failed");
// Asserts that an expression is never true outside reset.
`define ASSERT_NEVER(lbl, clk, rst, expr) \
  lbl: assert property (@(posedge clk) disable iff (rst) !(expr)) \
    else $error("forbidden condition seen");
`else
`define ASSERT_PROP(lbl, clk, rst, prop)
`define ASSERT_NEVER(lbl, clk, rst, expr)
`endif
`endif

/* rtl/core/cpi_pkg.sv */
// Package for the cubic pixel interpolator: widths, constants and the coefficient struct.
// Used by cpi_coef, cpi_lane and cubic_pixel_interpolator; depends on nothing.
package cpi_pkg;

  localparam int LANES         = 4;
  localparam int CH_W          = 8;
  localparam int PIX_W         = LANES * CH_W;
  localparam int FRAC_IN_W     = 16;
  localparam int FRAC_BITS_DEF = 16;

  // Doubled Catmull-Rom coefficients of one lane.
  localparam int A2_W = 11;
  localparam int B2_W = 12;
  localparam int C2_W = 9;
  localparam int D2_W = 9;

  localparam logic [CH_W-1:0] CH_MAX = 8'd255;

  // Coefficient stage plus four arithmetic stages in each lane.
  localparam int LATENCY = 5;

  typedef struct packed {
    logic signed [A2_W-1:0] a2;
    logic signed [B2_W-1:0] b2;
    logic signed [C2_W-1:0] c2;
    logic [D2_W-1:0]        d2;
  } coef_t;

endpackage

/* rtl/core/cpi_coef.sv */
// First pipeline stage of one lane: doubled Catmull-Rom coefficients from four samples.
// Depends on cpi_pkg.
module cpi_coef
  import cpi_pkg::*;
#(
  parameter int FRAC_BITS = FRAC_BITS_DEF
) (
  input  logic                 clk,
  input  logic [FRAC_IN_W-1:0] frac,
  input  logic [CH_W-1:0]      c0,
  input  logic [CH_W-1:0]      c1,
  input  logic [CH_W-1:0]      c2,
  input  logic [CH_W-1:0]      c3,
  output coef_t                coef,
  output logic [FRAC_BITS-1:0] f
);

  logic signed [12:0] s0, s1, s2, s3;
  logic signed [12:0] a2_full, b2_full, c2_full;
  coef_t              coef_next;

  always_comb begin
    s0 = $signed({5'b0, c0});
    s1 = $signed({5'b0, c1});
    s2 = $signed({5'b0, c2});
    s3 = $signed({5'b0, c3});
    a2_full = s3 - s0 + 13'sd3 * (s1 - s2);
    b2_full = 13'sd2 * s0 - 13'sd5 * s1 + 13'sd4 * s2 - s3;
    c2_full = s2 - s0;
    coef_next.a2 = a2_full[A2_W-1:0];
    coef_next.b2 = b2_full[B2_W-1:0];
    coef_next.c2 = c2_full[C2_W-1:0];
    coef_next.d2 = {c1, 1'b0};
  end

  // Fraction bits above FRAC_BITS are dropped; a wider fraction is zero extended.
  always_ff @(posedge clk) begin
    coef <= coef_next;
    f    <= FRAC_BITS'(frac);
  end

endmodule

/* rtl/core/cpi_lane.sv */
// Arithmetic stages of one lane: two Horner multiplies, a split final multiply,
// then the rounding add, shift and clamp. Depends on cpi_pkg.
module cpi_lane
  import cpi_pkg::*;
#(
  parameter int FRAC_BITS = FRAC_BITS_DEF
) (
  input  logic                 clk,
  input  coef_t                coef,
  input  logic [FRAC_BITS-1:0] f,
  output logic [CH_W-1:0]      ch
);

  localparam int X1W = FRAC_BITS + 13;
  localparam int X2W = 2 * FRAC_BITS + 14;
  localparam int XHW = X2W - FRAC_BITS;
  localparam int PHW = XHW + FRAC_BITS + 1;
  localparam int PLW = 2 * FRAC_BITS;
  localparam int SW  = 3 * FRAC_BITS + 16;
  localparam int VW  = SW - (3 * FRAC_BITS + 1);

  // Stage 2
  logic signed [X1W-1:0]  x1;
  logic [FRAC_BITS-1:0]   f2;
  logic signed [C2_W-1:0] c2_s2;
  logic [D2_W-1:0]        d2_s2;
  // Stage 3
  logic signed [X2W-1:0]  x2;
  logic [FRAC_BITS-1:0]   f3;
  logic [D2_W-1:0]        d2_s3;
  // Stage 4
  logic signed [PHW-1:0]  ph;
  logic [PLW-1:0]         pl;
  logic [D2_W-1:0]        d2_s4;
  // Stage 5
  logic signed [X1W-1:0]  x1_next;
  logic signed [X2W-1:0]  x2_next;
  logic signed [XHW-1:0]  xh;
  logic signed [SW-1:0]   sum;
  logic signed [VW-1:0]   v;
  logic [CH_W-1:0]        ch_next;

  always_comb begin
    x1_next = X1W'($signed(coef.a2) * $signed({1'b0, f}))
            + (X1W'($signed(coef.b2)) <<< FRAC_BITS);
    x2_next = X2W'(x1 * $signed({1'b0, f2}))
            + (X2W'(c2_s2) <<< (2 * FRAC_BITS));
    xh      = x2[X2W-1:FRAC_BITS];
    // Exact: floor((x2*f + (D2+1)*2^3F) / 2^(3F+1)) gives the half-up rounded value.
    sum = (SW'(ph) <<< FRAC_BITS)
        + SW'($signed({1'b0, pl}))
        + (SW'($signed({1'b0, d2_s4} + 10'd1)) <<< (3 * FRAC_BITS));
    v   = VW'(sum >>> (3 * FRAC_BITS + 1));
    if (v < 0) begin
      ch_next = '0;
    end else if (v > VW'($signed({1'b0, CH_MAX}))) begin
      ch_next = CH_MAX;
    end else begin
      ch_next = v[CH_W-1:0];
    end
  end

  always_ff @(posedge clk) begin
    x1    <= x1_next;
    f2    <= f;
    c2_s2 <= coef.c2;
    d2_s2 <= coef.d2;

    x2    <= x2_next;
    f3    <= f2;
    d2_s3 <= d2_s2;

    // The last multiply is split into a signed high part and an unsigned low limb.
    ph    <= PHW'(xh * $signed({1'b0, f3}));
    pl    <= x2[FRAC_BITS-1:0] * f3;
    d2_s4 <= d2_s3;

    ch    <= ch_next;
  end

endmodule

/* rtl/core/cubic_pixel_interpolator.sv */
// Catmull-Rom cubic interpolation of four packed pixels, four 8-bit lanes in parallel.
// done rises once the accepted samples have passed every lane stage; the result beat is valid while done is high.
// Throughput: one beat per cycle while rst is low, with no stall, since the receiver cannot hold results off.
// The five-stage lane pipeline (coefficients, two Horner multiplies, split multiply,
// round and clamp) sets the latency. Reset (rst, synchronous) clears only the valid bits.
// Depends on cpi_pkg, cpi_coef, cpi_lane and assert_macros.svh.
`include "assert_macros.svh"
module cubic_pixel_interpolator
  import cpi_pkg::*;
#(
  parameter int FRAC_BITS = FRAC_BITS_DEF
) (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 start,
  output logic                 busy,
  input  logic [FRAC_IN_W-1:0] frac,
  input  logic [PIX_W-1:0]     pix0,
  input  logic [PIX_W-1:0]     pix1,
  input  logic [PIX_W-1:0]     pix2,
  input  logic [PIX_W-1:0]     pix3,
  output logic                 done,
  output logic [PIX_W-1:0]     pix_out
);

  logic               accept;
  logic [LATENCY-1:0] vld;

  assign busy   = rst;
  assign accept = start && !busy;
  assign done   = vld[LATENCY-1];

  always_ff @(posedge clk) begin
    if (rst) begin
      vld <= '0;
    end else begin
      vld <= {vld[LATENCY-2:0], accept};
    end
  end

  for (genvar k = 0; k < LANES; k++) begin : g_lane
    coef_t                coef;
    logic [FRAC_BITS-1:0] f;

    cpi_coef #(.FRAC_BITS(FRAC_BITS)) u_coef (
      .clk  (clk),
      .frac (frac),
      .c0   (pix0[k*CH_W +: CH_W]),
      .c1   (pix1[k*CH_W +: CH_W]),
      .c2   (pix2[k*CH_W +: CH_W]),
      .c3   (pix3[k*CH_W +: CH_W]),
      .coef (coef),
      .f    (f)
    );

    cpi_lane #(.FRAC_BITS(FRAC_BITS)) u_lane (
      .clk  (clk),
      .coef (coef),
      .f    (f),
      .ch   (pix_out[k*CH_W +: CH_W])
    );
  end

  property p_latency;
    accept |-> ##LATENCY done;
  endproperty

  property p_no_spurious;
    done |-> $past(accept, LATENCY);
  endproperty

  // A flat neighborhood interpolates to itself.
  property p_flat;
    done && $past(accept && pix0 == pix1 && pix1 == pix2 && pix2 == pix3, LATENCY)
      |-> pix_out == $past(pix1, LATENCY);
  endproperty

  // At position zero the result is the second pixel.
  property p_zero_pos;
    done && $past(accept && (FRAC_BITS'(frac) == '0), LATENCY)
      |-> pix_out == $past(pix1, LATENCY);
  endproperty

  `ASSERT_PROP(a_latency, clk, rst, p_latency)
  `ASSERT_PROP(a_no_spurious, clk, rst, p_no_spurious)
  `ASSERT_PROP(a_flat, clk, rst, p_flat)
  `ASSERT_PROP(a_zero_pos, clk, rst, p_zero_pos)

endmodule
